// ===== design/lsp_pkg.sv =====
package lsp_pkg;

  localparam int W  = 32;
  localparam int F  = 16;
  localparam int QB = W + F;
  localparam int PW = 2 * W;

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    logic  clip;
    word_t v;
  } res_t;

  typedef struct packed {
    word_t [8:0] a;
    word_t [2:0] r;
    word_t [1:0] f;
    word_t [5:0] p;
    word_t [2:0] x;
    logic        sing;
    logic        sat;
  } ctx_t;

  typedef struct packed {
    logic          neg;
    word_t         md;
    logic [W:0]    rem;
    logic [QB-1:0] nq;
  } div_t;

  function automatic word_t magn(input word_t v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic res_t pack(input logic neg, input logic [PW-1:0] mag);
    res_t          o;
    logic [PW-1:0] lim;
    lim    = PW'(1) << (W - 1);
    o.clip = 1'b0;
    if (neg) begin
      if (mag > lim) begin
        o.clip = 1'b1;
        o.v    = lim[W-1:0];
      end else begin
        o.v = ~mag[W-1:0] + 1'b1;
      end
    end else begin
      if (mag > lim - 1'b1) begin
        o.clip = 1'b1;
        o.v    = W'(lim - 1'b1);
      end else begin
        o.v = mag[W-1:0];
      end
    end
    return o;
  endfunction

  function automatic res_t qmul(input word_t a, input word_t b);
    logic [PW-1:0] pr;
    pr = PW'(magn(a)) * PW'(magn(b));
    pr = (pr + (PW'(1) << (F - 1))) >> F;
    return pack(a[W-1] ^ b[W-1], pr);
  endfunction

  function automatic res_t qsub(input word_t a, input word_t b);
    logic [W:0] d;
    logic [W:0] mag;
    d   = {a[W-1], a} - {b[W-1], b};
    mag = d[W] ? (~d + 1'b1) : d;
    return pack(d[W], PW'(mag));
  endfunction

  function automatic div_t div_init(input word_t a, input word_t dv);
    div_t d;
    d.neg = a[W-1] ^ dv[W-1];
    d.md  = magn(dv);
    d.rem = '0;
    d.nq  = QB'(magn(a)) << F;
    return d;
  endfunction

  function automatic div_t div_step(input div_t d);
    div_t       o;
    logic [W:0] t;
    logic       ge;
    t     = {d.rem[W-1:0], d.nq[QB-1]};
    ge    = t >= {1'b0, d.md};
    o.neg = d.neg;
    o.md  = d.md;
    o.rem = ge ? (t - {1'b0, d.md}) : t;
    o.nq  = {d.nq[QB-2:0], ge};
    return o;
  endfunction

  function automatic res_t qdiv_fin(input div_t d);
    logic [QB-1:0] q;
    logic [W+1:0]  r2;
    r2 = {d.rem, 1'b0};
    q  = d.nq + QB'(r2 >= {2'b00, d.md});
    return pack(d.neg, PW'(q));
  endfunction

endpackage

// ===== design/linear_solve_3x3_pivot_unit.sv =====
// channel  | signals                         | word
// in       | in_tvalid/in_tready/in_tdata    | m_r0c0..m_r2c2, rhs0..rhs2
// out      | out_tvalid/out_tready/out_tdata | sol0..sol2, flags in out_tuser
// One word enters per cycle unless a held output word stalls the pipe.
// Six 48-cell divider chains, one quotient bit per cell, set the latency.
// rst_n clears the valid bits only.
// A held output word stalls the whole pipe; in_tready follows out_tready then.
module linear_solve_3x3_pivot_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [383:0] in_tdata,   // m_r0c0..m_r2c2, rhs0, rhs1, rhs2
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // sol0, sol1, sol2
  output logic [1:0]   out_tuser   // singular, saturated
);
  import lsp_pkg::*;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // pivot row select
  logic  s0_v_r;
  ctx_t  s0_r, s0_nxt;
  word_t im [11:0];
  logic [1:0] pv;

  always_comb begin
    for (int k = 0; k < 12; k++) im[k] = in_tdata[W*k +: W];
    pv = 2'd0;
    if (magn(im[3]) > magn(im[0])) pv = 2'd1;
    if (magn(im[6]) > ((pv == 2'd1) ? magn(im[3]) : magn(im[0]))) pv = 2'd2;
    s0_nxt = '0;
    for (int k = 0; k < 9; k++) s0_nxt.a[k] = im[k];
    for (int k = 0; k < 3; k++) s0_nxt.r[k] = im[9+k];
    for (int j = 0; j < 3; j++) begin
      s0_nxt.a[j]         = im[3*pv + j];
      s0_nxt.a[3*pv + j]  = im[j];
    end
    s0_nxt.r[0]  = im[9 + pv];
    s0_nxt.r[pv] = im[9];
    s0_nxt.sing  = (s0_nxt.a[0] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (en) s0_v_r <= in_tvalid;
    if (en) s0_r <= s0_nxt;
  end

  // f1 = a3 / a0
  logic d1_v; res_t d1_q; ctx_t d1_c, d1_m;
  lsp_div u_d1 (.clk(clk), .rst_n(rst_n), .en(en), .v_i(s0_v_r),
    .dividend(s0_r.a[3]), .divisor(s0_r.a[0]), .c_i(s0_r),
    .v_o(d1_v), .q_o(d1_q), .c_o(d1_c));
  always_comb begin
    d1_m      = d1_c;
    d1_m.f[0] = d1_q.v;
    d1_m.sat  = d1_c.sat | d1_q.clip;
  end

  // f2 = a6 / a0
  logic d2_v; res_t d2_q; ctx_t d2_c;
  lsp_div u_d2 (.clk(clk), .rst_n(rst_n), .en(en), .v_i(d1_v),
    .dividend(d1_m.a[6]), .divisor(d1_m.a[0]), .c_i(d1_m),
    .v_o(d2_v), .q_o(d2_q), .c_o(d2_c));

  logic m1_v_r; ctx_t m1_r, m1_nxt; res_t m1p [5:0];
  always_comb begin
    m1_nxt      = d2_c;
    m1_nxt.f[1] = d2_q.v;
    m1p[0] = qmul(d2_c.f[0], d2_c.a[1]);
    m1p[1] = qmul(d2_c.f[0], d2_c.a[2]);
    m1p[2] = qmul(d2_c.f[0], d2_c.r[0]);
    m1p[3] = qmul(d2_q.v, d2_c.a[1]);
    m1p[4] = qmul(d2_q.v, d2_c.a[2]);
    m1p[5] = qmul(d2_q.v, d2_c.r[0]);
    m1_nxt.sat = d2_c.sat | d2_q.clip;
    for (int k = 0; k < 6; k++) begin
      m1_nxt.p[k] = m1p[k].v;
      m1_nxt.sat  = m1_nxt.sat | m1p[k].clip;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) m1_v_r <= 1'b0;
    else if (en) m1_v_r <= d2_v;
    if (en) m1_r <= m1_nxt;
  end

  logic s1_v_r; ctx_t s1_r, s1_nxt; res_t s1d [5:0];
  always_comb begin
    s1_nxt = m1_r;
    s1d[0] = qsub(m1_r.a[4], m1_r.p[0]);
    s1d[1] = qsub(m1_r.a[5], m1_r.p[1]);
    s1d[2] = qsub(m1_r.r[1], m1_r.p[2]);
    s1d[3] = qsub(m1_r.a[7], m1_r.p[3]);
    s1d[4] = qsub(m1_r.a[8], m1_r.p[4]);
    s1d[5] = qsub(m1_r.r[2], m1_r.p[5]);
    s1_nxt.a[4] = s1d[0].v;
    s1_nxt.a[5] = s1d[1].v;
    s1_nxt.r[1] = s1d[2].v;
    s1_nxt.a[7] = s1d[3].v;
    s1_nxt.a[8] = s1d[4].v;
    s1_nxt.r[2] = s1d[5].v;
    for (int k = 0; k < 6; k++) s1_nxt.sat = s1_nxt.sat | s1d[k].clip;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= m1_v_r;
    if (en) s1_r <= s1_nxt;
  end

  // second pivot swap
  logic w2_v_r; ctx_t w2_r, w2_nxt;
  always_comb begin
    w2_nxt = s1_r;
    if (magn(s1_r.a[4]) < magn(s1_r.a[7])) begin
      w2_nxt.a[4] = s1_r.a[7];
      w2_nxt.a[7] = s1_r.a[4];
      w2_nxt.a[5] = s1_r.a[8];
      w2_nxt.a[8] = s1_r.a[5];
      w2_nxt.r[1] = s1_r.r[2];
      w2_nxt.r[2] = s1_r.r[1];
    end
    w2_nxt.sing = s1_r.sing | (w2_nxt.a[4] == '0);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) w2_v_r <= 1'b0;
    else if (en) w2_v_r <= s1_v_r;
    if (en) w2_r <= w2_nxt;
  end

  // f = a7 / a4
  logic d3_v; res_t d3_q; ctx_t d3_c;
  lsp_div u_d3 (.clk(clk), .rst_n(rst_n), .en(en), .v_i(w2_v_r),
    .dividend(w2_r.a[7]), .divisor(w2_r.a[4]), .c_i(w2_r),
    .v_o(d3_v), .q_o(d3_q), .c_o(d3_c));

  logic m2_v_r; ctx_t m2_r, m2_nxt; res_t m2p [1:0];
  always_comb begin
    m2_nxt      = d3_c;
    m2p[0]      = qmul(d3_q.v, d3_c.a[5]);
    m2p[1]      = qmul(d3_q.v, d3_c.r[1]);
    m2_nxt.p[0] = m2p[0].v;
    m2_nxt.p[1] = m2p[1].v;
    m2_nxt.sat  = d3_c.sat | d3_q.clip | m2p[0].clip | m2p[1].clip;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) m2_v_r <= 1'b0;
    else if (en) m2_v_r <= d3_v;
    if (en) m2_r <= m2_nxt;
  end

  logic s2_v_r; ctx_t s2_r, s2_nxt; res_t s2d [1:0];
  always_comb begin
    s2_nxt      = m2_r;
    s2d[0]      = qsub(m2_r.a[8], m2_r.p[0]);
    s2d[1]      = qsub(m2_r.r[2], m2_r.p[1]);
    s2_nxt.a[8] = s2d[0].v;
    s2_nxt.r[2] = s2d[1].v;
    s2_nxt.sat  = m2_r.sat | s2d[0].clip | s2d[1].clip;
    s2_nxt.sing = m2_r.sing | (s2d[0].v == '0);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= m2_v_r;
    if (en) s2_r <= s2_nxt;
  end

  // x2 = r2 / a8
  logic d4_v; res_t d4_q; ctx_t d4_c;
  lsp_div u_d4 (.clk(clk), .rst_n(rst_n), .en(en), .v_i(s2_v_r),
    .dividend(s2_r.r[2]), .divisor(s2_r.a[8]), .c_i(s2_r),
    .v_o(d4_v), .q_o(d4_q), .c_o(d4_c));

  logic m3_v_r; ctx_t m3_r, m3_nxt; res_t m3p [1:0];
  always_comb begin
    m3_nxt      = d4_c;
    m3_nxt.x[2] = d4_q.v;
    m3p[0]      = qmul(d4_c.a[5], d4_q.v);
    m3p[1]      = qmul(d4_c.a[2], d4_q.v);
    m3_nxt.p[0] = m3p[0].v;
    m3_nxt.p[1] = m3p[1].v;
    m3_nxt.sat  = d4_c.sat | d4_q.clip | m3p[0].clip | m3p[1].clip;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) m3_v_r <= 1'b0;
    else if (en) m3_v_r <= d4_v;
    if (en) m3_r <= m3_nxt;
  end

  logic s3_v_r; ctx_t s3_r, s3_nxt; res_t s3d [1:0];
  always_comb begin
    s3_nxt      = m3_r;
    s3d[0]      = qsub(m3_r.r[1], m3_r.p[0]);
    s3d[1]      = qsub(m3_r.r[0], m3_r.p[1]);
    s3_nxt.r[1] = s3d[0].v;
    s3_nxt.r[0] = s3d[1].v;
    s3_nxt.sat  = m3_r.sat | s3d[0].clip | s3d[1].clip;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= m3_v_r;
    if (en) s3_r <= s3_nxt;
  end

  // x1 = r1' / a4
  logic d5_v; res_t d5_q; ctx_t d5_c;
  lsp_div u_d5 (.clk(clk), .rst_n(rst_n), .en(en), .v_i(s3_v_r),
    .dividend(s3_r.r[1]), .divisor(s3_r.a[4]), .c_i(s3_r),
    .v_o(d5_v), .q_o(d5_q), .c_o(d5_c));

  logic m4_v_r; ctx_t m4_r, m4_nxt; res_t m4p;
  always_comb begin
    m4_nxt      = d5_c;
    m4_nxt.x[1] = d5_q.v;
    m4p         = qmul(d5_c.a[1], d5_q.v);
    m4_nxt.p[0] = m4p.v;
    m4_nxt.sat  = d5_c.sat | d5_q.clip | m4p.clip;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) m4_v_r <= 1'b0;
    else if (en) m4_v_r <= d5_v;
    if (en) m4_r <= m4_nxt;
  end

  logic s4_v_r; ctx_t s4_r, s4_nxt; res_t s4d;
  always_comb begin
    s4_nxt      = m4_r;
    s4d         = qsub(m4_r.r[0], m4_r.p[0]);
    s4_nxt.r[0] = s4d.v;
    s4_nxt.sat  = m4_r.sat | s4d.clip;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= m4_v_r;
    if (en) s4_r <= s4_nxt;
  end

  // x0 = r0'' / a0
  logic d6_v; res_t d6_q; ctx_t d6_c;
  lsp_div u_d6 (.clk(clk), .rst_n(rst_n), .en(en), .v_i(s4_v_r),
    .dividend(s4_r.r[0]), .divisor(s4_r.a[0]), .c_i(s4_r),
    .v_o(d6_v), .q_o(d6_q), .c_o(d6_c));

  logic        out_v_r;
  logic [95:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;
  always_comb begin
    if (d6_c.sing) begin
      out_data_nxt = '0;
      out_user_nxt = 2'b01;
    end else begin
      out_data_nxt = {d6_c.x[2], d6_c.x[1], d6_q.v};
      out_user_nxt = {d6_c.sat | d6_q.clip, 1'b0};
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= d6_v;
    if (en) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== design/lsp_div_cell.sv =====
module lsp_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  lsp_pkg::div_t d_i,
  input  lsp_pkg::ctx_t c_i,
  output logic          v_o,
  output lsp_pkg::div_t d_o,
  output lsp_pkg::ctx_t c_o
);
  import lsp_pkg::*;

  logic v_r;
  div_t d_r;
  ctx_t c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
    if (en) begin
      d_r <= div_step(d_i);
      c_r <= c_i;
    end
  end

  assign v_o = v_r;
  assign d_o = d_r;
  assign c_o = c_r;

endmodule

// ===== design/lsp_div.sv =====
module lsp_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_i,
  input  lsp_pkg::word_t dividend,
  input  lsp_pkg::word_t divisor,
  input  lsp_pkg::ctx_t  c_i,
  output logic           v_o,
  output lsp_pkg::res_t  q_o,
  output lsp_pkg::ctx_t  c_o
);
  import lsp_pkg::*;

  logic v   [QB+1];
  div_t d   [QB+1];
  ctx_t c   [QB+1];
  logic v_r;
  res_t q_r;
  ctx_t c_r;

  assign v[0] = v_i;
  assign d[0] = div_init(dividend, divisor);
  assign c[0] = c_i;

  for (genvar i = 0; i < QB; i++) begin : g_cell
    lsp_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (v[i]),
      .d_i   (d[i]),
      .c_i   (c[i]),
      .v_o   (v[i+1]),
      .d_o   (d[i+1]),
      .c_o   (c[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v[QB];
    end
    if (en) begin
      q_r <= qdiv_fin(d[QB]);
      c_r <= c[QB];
    end
  end

  assign v_o = v_r;
  assign q_o = q_r;
  assign c_o = c_r;

endmodule
